### src/bsc_pkg.sv
`default_nettype none

package bsc_pkg;

    // Default sizing of the breakpoint table and of the stored address.
    localparam int unsigned DefaultSlots = 16;
    localparam int unsigned DefaultAddressBits = 32;

    // Widths fixed by the item and result fields.
    localparam int unsigned KindBits = 3;
    localparam int unsigned InAddressBits = 32;
    localparam int unsigned DepthBits = 8;
    localparam int unsigned StatusBits = 3;
    localparam int unsigned EntriesBits = 5;

    // Item kinds.
    localparam logic [KindBits-1:0] KIND_EVAL      = 3'd0;
    localparam logic [KindBits-1:0] KIND_SET       = 3'd1;
    localparam logic [KindBits-1:0] KIND_CLEAR     = 3'd2;
    localparam logic [KindBits-1:0] KIND_QUERY     = 3'd3;
    localparam logic [KindBits-1:0] KIND_STEP_OVER = 3'd4;
    localparam logic [KindBits-1:0] KIND_STEP_INTO = 3'd5;
    localparam logic [KindBits-1:0] KIND_CONTINUE  = 3'd6;

    // Result status codes.
    localparam logic [StatusBits-1:0] ST_DONE     = 3'd0;
    localparam logic [StatusBits-1:0] ST_HALTED   = 3'd1;
    localparam logic [StatusBits-1:0] ST_RELEASED = 3'd2;
    localparam logic [StatusBits-1:0] ST_FULL     = 3'd3;
    localparam logic [StatusBits-1:0] ST_DUP      = 3'd4;
    localparam logic [StatusBits-1:0] ST_NOTFOUND = 3'd5;
    localparam logic [StatusBits-1:0] ST_IGNORED  = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture a new item beat
        logic compare;    // search the table and fetch the last entry
        logic commit;     // update the state and register the result
        logic cfg_write;  // write the enable register
    } t_dp_cmd;

endpackage

`default_nettype wire

### src/bsc_ctrl.sv
`default_nettype none

module bsc_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    input  wire               i_cfg_valid,
    output logic              busy,
    output logic              o_cfg_ready,
    output bsc_pkg::t_dp_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Only the compare cycle blocks a new item; the response cycle overlaps the next load.
    assign busy = (r_state == S_CMP);
    // The enable register is written only when idle with no item beat offered.
    assign o_cfg_ready = (r_state == S_IDLE) && !start;

    always_comb begin
        o_cmd.load = start && !busy;
        o_cmd.compare = (r_state == S_CMP);
        o_cmd.commit = (r_state == S_RESP);
        o_cmd.cfg_write = i_cfg_valid && o_cfg_ready;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (start) begin
                    n_state = S_CMP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### src/bsc_datapath.sv
`default_nettype none

module bsc_datapath #(
    parameter int unsigned BREAKPOINT_SLOTS = bsc_pkg::DefaultSlots,
    parameter int unsigned ADDRESS_BITS = bsc_pkg::DefaultAddressBits
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire  bsc_pkg::t_dp_cmd                i_cmd,
    input  wire                                   i_cfg_data,
    input  wire  [bsc_pkg::KindBits-1:0]          i_kind,
    input  wire  [bsc_pkg::InAddressBits-1:0]     i_node_address,
    input  wire  [bsc_pkg::DepthBits-1:0]         i_node_depth,
    output logic                                  o_result_valid,
    output logic [bsc_pkg::StatusBits-1:0]        o_status,
    output logic                                  o_match,
    output logic                                  o_paused_now,
    output logic [bsc_pkg::EntriesBits-1:0]       o_entries_used
);

    localparam int unsigned CW = $clog2(BREAKPOINT_SLOTS + 1);
    localparam int unsigned IW = (BREAKPOINT_SLOTS > 1) ? $clog2(BREAKPOINT_SLOTS) : 1;
    localparam int unsigned KB =
        (ADDRESS_BITS < bsc_pkg::InAddressBits) ? ADDRESS_BITS : bsc_pkg::InAddressBits;
    localparam int unsigned DW = bsc_pkg::DepthBits;

    // Item beat registers.
    logic [bsc_pkg::KindBits-1:0] r_kind;
    logic [ADDRESS_BITS-1:0]      r_addr;
    logic [DW-1:0]                r_depth;

    // Breakpoint table and debug state.
    logic [ADDRESS_BITS-1:0] r_store [BREAKPOINT_SLOTS];
    logic [CW-1:0]           r_count;
    logic                    r_enable;
    logic                    r_paused;
    logic                    r_waiting;
    logic                    r_step_pending;
    logic [DW-1:0]           r_level;
    logic [DW-1:0]           r_last_depth;
    logic                    r_have_last;

    // Compare stage results.
    logic [BREAKPOINT_SLOTS-1:0] r_hit_vec;
    logic [ADDRESS_BITS-1:0]     r_last_entry;
    logic [BREAKPOINT_SLOTS-1:0] n_hit_vec;
    logic [CW-1:0]               n_last_idx;

    // Response stage next values.
    logic [CW-1:0]                  n_count;
    logic                           n_paused;
    logic                           n_waiting;
    logic                           n_step_pending;
    logic [DW-1:0]                  n_level;
    logic [DW-1:0]                  n_last_depth;
    logic                           n_have_last;
    logic [bsc_pkg::StatusBits-1:0] n_status;
    logic                           n_match;
    logic                           n_wr_en;
    logic [IW-1:0]                  n_wr_idx;
    logic [ADDRESS_BITS-1:0]        n_wr_data;
    logic                           n_hit;
    logic [IW-1:0]                  n_hit_idx;

    // Output registers.
    logic                           r_result_valid;
    logic [bsc_pkg::StatusBits-1:0] r_status;
    logic                           r_match;
    logic                           r_paused_now;
    logic [bsc_pkg::EntriesBits-1:0] r_entries;

    // Parallel compare against the occupied entries.
    always_comb begin
        for (int i = 0; i < BREAKPOINT_SLOTS; i++) begin
            n_hit_vec[i] = (r_count > CW'(i)) && (r_store[i] == r_addr);
        end
        n_last_idx = r_count - CW'(1);
    end

    // Lowest matching slot; the table never holds duplicates.
    always_comb begin
        n_hit = |r_hit_vec;
        n_hit_idx = '0;
        for (int i = BREAKPOINT_SLOTS - 1; i >= 0; i--) begin
            if (r_hit_vec[i]) begin
                n_hit_idx = IW'(i);
            end
        end
    end

    // Decision for the item and the state it leaves behind.
    always_comb begin
        n_count = r_count;
        n_paused = r_paused;
        n_waiting = r_waiting;
        n_step_pending = r_step_pending;
        n_level = r_level;
        n_last_depth = r_last_depth;
        n_have_last = r_have_last;
        n_status = bsc_pkg::ST_DONE;
        n_match = 1'b0;
        n_wr_en = 1'b0;
        n_wr_idx = r_count[IW-1:0];
        n_wr_data = r_addr;
        case (r_kind) inside
            bsc_pkg::KIND_EVAL: begin
                if (r_waiting) begin
                    n_status = bsc_pkg::ST_IGNORED;
                end else begin
                    n_last_depth = r_depth;
                    n_have_last = 1'b1;
                    if (r_enable) begin
                        if (n_hit) begin
                            n_match = 1'b1;
                            n_paused = 1'b1;
                        end
                        if ((r_level != '0) && (r_depth <= r_level)) begin
                            n_paused = 1'b1;
                            n_level = '0;
                        end
                        if (n_paused) begin
                            if (r_step_pending) begin
                                n_step_pending = 1'b0;
                                n_status = bsc_pkg::ST_RELEASED;
                            end else begin
                                n_waiting = 1'b1;
                                n_status = bsc_pkg::ST_HALTED;
                            end
                        end
                    end
                end
            end
            bsc_pkg::KIND_SET: begin
                if ((r_addr == '0) || n_hit) begin
                    n_status = bsc_pkg::ST_DUP;
                end else if (r_count < CW'(BREAKPOINT_SLOTS)) begin
                    n_wr_en = 1'b1;
                    n_count = r_count + CW'(1);
                end else begin
                    n_status = bsc_pkg::ST_FULL;
                end
            end
            bsc_pkg::KIND_CLEAR: begin
                if (!n_hit) begin
                    n_status = bsc_pkg::ST_NOTFOUND;
                end else begin
                    n_count = r_count - CW'(1);
                    n_wr_en = 1'b1;
                    n_wr_idx = n_hit_idx;
                    n_wr_data = r_last_entry;
                end
            end
            bsc_pkg::KIND_QUERY: begin
                if (!r_enable) begin
                    n_status = bsc_pkg::ST_IGNORED;
                end else begin
                    n_match = n_hit;
                end
            end
            bsc_pkg::KIND_STEP_OVER, bsc_pkg::KIND_CONTINUE: begin
                if (!r_paused) begin
                    n_status = bsc_pkg::ST_IGNORED;
                end else begin
                    n_paused = 1'b0;
                    if ((r_kind == bsc_pkg::KIND_STEP_OVER) && r_have_last) begin
                        n_level = r_last_depth;
                    end
                    if (r_waiting) begin
                        n_waiting = 1'b0;
                        n_status = bsc_pkg::ST_RELEASED;
                    end
                end
            end
            bsc_pkg::KIND_STEP_INTO: begin
                if (!r_paused) begin
                    n_status = bsc_pkg::ST_IGNORED;
                end else if (r_waiting) begin
                    n_waiting = 1'b0;
                    n_status = bsc_pkg::ST_RELEASED;
                end else begin
                    n_step_pending = 1'b1;
                end
            end
            default: begin
                n_status = bsc_pkg::ST_IGNORED;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_count <= '0;
            r_paused <= 1'b0;
            r_waiting <= 1'b0;
            r_step_pending <= 1'b0;
            r_level <= '0;
            r_last_depth <= '0;
            r_have_last <= 1'b0;
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= i_cmd.commit;
            if (i_cmd.cfg_write) begin
                r_enable <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_count <= n_count;
                r_paused <= n_paused;
                r_waiting <= n_waiting;
                r_step_pending <= n_step_pending;
                r_level <= n_level;
                r_last_depth <= n_last_depth;
                r_have_last <= n_have_last;
            end
        end
    end

    // Payload registers: item beat, compare results, table and result beat.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_addr <= ADDRESS_BITS'(i_node_address[KB-1:0]);
            r_depth <= i_node_depth;
        end
        if (i_cmd.compare) begin
            r_hit_vec <= n_hit_vec;
            r_last_entry <= r_store[n_last_idx[IW-1:0]];
        end
        if (i_cmd.commit) begin
            if (n_wr_en) begin
                r_store[n_wr_idx] <= n_wr_data;
            end
            r_status <= n_status;
            r_match <= n_match;
            r_paused_now <= n_paused;
            r_entries <= bsc_pkg::EntriesBits'(n_count);
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_status = r_status;
    assign o_match = r_match;
    assign o_paused_now = r_paused_now;
    assign o_entries_used = r_entries;

endmodule

`default_nettype wire

### src/breakpoint_step_controller.sv
// Items pass the item, compare and result registers; the result beat is on the outputs for
// one cycle. A new item can load during the response cycle; busy is high for the compare
// cycle only, which searches the whole table in parallel before the response cycle commits.
// Reset (i_rst_n low, synchronous) empties the table, clears pause and step state and
// disables debugging. The receiver cannot stall, so results never back up.
`default_nettype none

module breakpoint_step_controller #(
    parameter int unsigned BREAKPOINT_SLOTS = bsc_pkg::DefaultSlots,
    parameter int unsigned ADDRESS_BITS = bsc_pkg::DefaultAddressBits
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                start,
    output logic                               busy,
    input  wire  [bsc_pkg::KindBits-1:0]       i_kind,
    input  wire  [bsc_pkg::InAddressBits-1:0]  i_node_address,
    input  wire  [bsc_pkg::DepthBits-1:0]      i_node_depth,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire                                i_cfg_data,
    output logic                               o_result_valid,
    output logic [bsc_pkg::StatusBits-1:0]     o_status,
    output logic                               o_match,
    output logic                               o_paused_now,
    output logic [bsc_pkg::EntriesBits-1:0]    o_entries_used
);

    bsc_pkg::t_dp_cmd w_cmd;

    // Sequencing of each item beat.
    bsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_cfg_valid (i_cfg_valid),
        .busy        (busy),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (w_cmd)
    );

    // Breakpoint table, debug state and result registers.
    bsc_datapath #(
        .BREAKPOINT_SLOTS (BREAKPOINT_SLOTS),
        .ADDRESS_BITS     (ADDRESS_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cfg_data     (i_cfg_data),
        .i_kind         (i_kind),
        .i_node_address (i_node_address),
        .i_node_depth   (i_node_depth),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_match        (o_match),
        .o_paused_now   (o_paused_now),
        .o_entries_used (o_entries_used)
    );

endmodule

`default_nettype wire
